@@ rtl/udp_port_offset_signature_matcher_core_macros.svh @@
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef UDP_PORT_OFFSET_SIGNATURE_MATCHER_CORE_MACROS_SVH
`define UDP_PORT_OFFSET_SIGNATURE_MATCHER_CORE_MACROS_SVH

// Same-cycle implication.
`define UPSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UPSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/upsm_pkg.sv @@
`timescale 1ns / 1ps
package upsm_pkg;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 2;
  localparam int OFF_W    = 11;
  localparam int LEN_W    = 5;
  localparam int CPOS_W   = 5;
  localparam int PORT_W   = 16;
  localparam int SCNT_W   = 3;
  localparam int MASK_W   = 4;
  localparam int COUNT_W  = 64;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 72;

  localparam logic [PORT_W-1:0] PORT_RESET = 16'd5001;

  localparam int HDR_BYTES        = 42;
  localparam int POS_ETYPE_HI     = 12;
  localparam int POS_ETYPE_LO     = 13;
  localparam int POS_VER_IHL      = 14;
  localparam int POS_PROTO        = 23;
  localparam int POS_DPORT_HI     = 36;
  localparam int POS_DPORT_LO     = 37;

  localparam logic [BYTE_W-1:0] ETYPE_HI_VAL = 8'h08;
  localparam logic [BYTE_W-1:0] ETYPE_LO_VAL = 8'h00;
  localparam logic [BYTE_W-1:0] VER_IHL_VAL  = 8'h45;
  localparam logic [BYTE_W-1:0] PROTO_UDP    = 8'd17;

  localparam logic REG_INSPECT_PORT = 1'b0;
  localparam logic REG_SIG_COUNT    = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME_BYTE = 2'd0,
    CMD_SET_SIG    = 2'd1,
    CMD_SET_CHAR   = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;
    logic [IDX_W-1:0]    sig_index;
    logic [OFF_W-1:0]    sig_offset;
    logic [LEN_W-1:0]    sig_length;
    logic [CPOS_W-1:0]   char_pos;
  } item_t;

  typedef struct packed {
    logic pos_ok;
    logic header_good;
    logic short_frame;
  } hdr_status_t;

  typedef struct packed {
    logic              fire;
    logic              frame;
    logic              last;
    logic [BYTE_W-1:0] data;
  } s2_ctl_t;

endpackage

@@ rtl/upsm_hdr_check.sv @@
`timescale 1ns / 1ps
module upsm_hdr_check #(
  parameter int MAX_FRAME = 2048,
  parameter int POS_W     = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [upsm_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           last_byte,
  input  logic [upsm_pkg::PORT_W-1:0]    inspect_port,
  output logic [POS_W-1:0]               pos,
  output logic [POS_W-1:0]               flen,
  output upsm_pkg::hdr_status_t          status
);

  logic                          header_ok;
  logic                          header_ok_next;
  logic [upsm_pkg::BYTE_W-1:0]   port_high;
  logic [upsm_pkg::BYTE_W-1:0]   port_high_next;
  logic                          pos_ok;

  assign pos_ok = (pos != POS_W'(MAX_FRAME));
  assign flen   = pos_ok ? pos + POS_W'(1) : pos;

  always_comb begin
    header_ok_next = header_ok;
    port_high_next = port_high;
    if (pos_ok) begin
      if (pos == POS_W'(upsm_pkg::POS_ETYPE_HI) && data_byte != upsm_pkg::ETYPE_HI_VAL)
        header_ok_next = 1'b0;
      if (pos == POS_W'(upsm_pkg::POS_ETYPE_LO) && data_byte != upsm_pkg::ETYPE_LO_VAL)
        header_ok_next = 1'b0;
      if (pos == POS_W'(upsm_pkg::POS_VER_IHL) && data_byte != upsm_pkg::VER_IHL_VAL)
        header_ok_next = 1'b0;
      if (pos == POS_W'(upsm_pkg::POS_PROTO) && data_byte != upsm_pkg::PROTO_UDP)
        header_ok_next = 1'b0;
      if (pos == POS_W'(upsm_pkg::POS_DPORT_HI))
        port_high_next = data_byte;
      if (pos == POS_W'(upsm_pkg::POS_DPORT_LO) && {port_high, data_byte} != inspect_port)
        header_ok_next = 1'b0;
    end
  end

  assign status.pos_ok      = pos_ok;
  assign status.header_good = header_ok_next;
  assign status.short_frame = (flen < POS_W'(upsm_pkg::HDR_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      header_ok <= 1'b1;
      port_high <= '0;
    end else if (fire) begin
      if (last_byte) begin
        pos       <= '0;
        header_ok <= 1'b1;
        port_high <= '0;
      end else begin
        pos       <= flen;
        header_ok <= header_ok_next;
        port_high <= port_high_next;
      end
    end
  end

endmodule

@@ rtl/upsm_sig_lane.sv @@
`timescale 1ns / 1ps
module upsm_sig_lane #(
  parameter int LANE     = 0,
  parameter int MAX_WORD = 20,
  parameter int POS_W    = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s1_fire,
  input  upsm_pkg::item_t        item,
  input  logic [POS_W-1:0]       pos,
  input  logic [POS_W-1:0]       flen,
  input  logic                   pos_ok,
  input  upsm_pkg::s2_ctl_t      s2,
  output logic                   lane_ok
);

  localparam int AW   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LREQ = $clog2(MAX_WORD + 1);
  localparam int LW   = (LREQ > upsm_pkg::LEN_W) ? LREQ : upsm_pkg::LEN_W;
  localparam int PW   = (POS_W > upsm_pkg::OFF_W) ? POS_W : upsm_pkg::OFF_W;
  localparam int CW   = PW + 2;

  logic [upsm_pkg::OFF_W-1:0]   off_r;
  logic [LW-1:0]                len_r;
  logic [upsm_pkg::BYTE_W-1:0]  chars [MAX_WORD];

  logic                         sel;
  logic [LW-1:0]                len_clamped;
  logic [CW-1:0]                rel;
  logic [CW-1:0]                diff;
  logic [CW-1:0]                cpos_w;
  logic                         in_win;
  logic                         fits;

  logic [upsm_pkg::BYTE_W-1:0]  rd_data;
  logic                         hit;
  logic                         zero_len;
  logic                         fits_r;
  logic                         match_so_far;
  logic                         match_now;

  assign sel         = (int'(item.sig_index) == LANE);
  assign len_clamped = (LW'(item.sig_length) > LW'(MAX_WORD)) ? LW'(MAX_WORD)
                                                              : LW'(item.sig_length);
  assign rel    = CW'(pos) - CW'(upsm_pkg::HDR_BYTES);
  assign diff   = rel - CW'(off_r);
  assign cpos_w = CW'(item.char_pos);
  assign in_win = (item.cmd == upsm_pkg::CMD_FRAME_BYTE) && pos_ok &&
                  (CW'(pos) >= CW'(upsm_pkg::HDR_BYTES)) &&
                  (rel >= CW'(off_r)) && (diff < CW'(len_r));
  assign fits   = (CW'(upsm_pkg::HDR_BYTES) + CW'(off_r) + CW'(len_r)) <= CW'(flen);

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (item.cmd == upsm_pkg::CMD_SET_SIG && sel) begin
        off_r <= item.sig_offset;
        len_r <= len_clamped;
      end
      if (item.cmd == upsm_pkg::CMD_SET_CHAR && sel && cpos_w < CW'(MAX_WORD))
        chars[cpos_w[AW-1:0]] <= item.data_byte;
      if (in_win)
        rd_data <= chars[diff[AW-1:0]];
      hit      <= in_win;
      zero_len <= (len_r == '0);
      fits_r   <= fits;
    end
  end

  assign match_now = match_so_far && !(hit && rd_data != s2.data);
  assign lane_ok   = zero_len || (match_now && fits_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_so_far <= 1'b1;
    end else if (s2.fire && s2.frame) begin
      match_so_far <= s2.last ? 1'b1 : match_now;
    end
  end

endmodule

@@ rtl/udp_port_offset_signature_matcher_core.sv @@
// UDP destination port filter with fixed-offset payload signature matching.
// s_axis carries one item per transfer: tuser is the command (frame byte,
// set signature offset/length, set signature character), tlast marks the
// final byte of a frame. Only a frame byte with tlast set yields a result.
// m_axis carries one result per frame: forward, too_short, match mask and
// the running count of forwarded frames.
// cfg_we/cfg_index/cfg_data write inspect_port (0) and signature_count (1);
// write them only while no frame is in flight.
// Throughput: one item per cycle unless a result waits on a stalled m_axis.
// The last frame byte passes the input register, the header and window stage
// with a registered signature read, then compare and result.
// Reset clears the pipeline, the frame state, the counter and the config
// registers; signature table contents are kept until rewritten.
// When m_axis stalls, the waiting result holds and items that give no result
// keep flowing until the next result reaches the compare stage.
`timescale 1ns / 1ps
`include "udp_port_offset_signature_matcher_core_macros.svh"
module udp_port_offset_signature_matcher_core #(
  parameter int NUM_SIGNATURES = 4,
  parameter int MAX_WORD       = 20,
  parameter int MAX_FRAME      = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte[7:0], sig_index[9:8], sig_offset[20:10], sig_length[25:21],
  // char_pos[30:26], zero[31]
  input  logic [upsm_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // command[1:0]
  input  logic [upsm_pkg::CMD_W-1:0]        s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // forward[0], too_short[1], match_mask[5:2], inspected_count[69:6], zero[71:70]
  output logic [upsm_pkg::M_DATA_W-1:0]     m_axis_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [upsm_pkg::PORT_W-1:0]       cfg_data
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);

  logic [upsm_pkg::PORT_W-1:0]   inspect_port;
  logic [upsm_pkg::SCNT_W-1:0]   signature_count;

  logic                          s1_valid;
  upsm_pkg::item_t               s1_item;
  logic                          s1_adv;
  logic                          s1_fire;

  logic                          s2_valid;
  logic                          s2_frame;
  logic                          s2_last;
  logic [upsm_pkg::BYTE_W-1:0]   s2_byte;
  logic                          s2_fwd;
  logic                          s2_short;
  logic                          s2_emit;
  logic                          s2_adv;
  logic                          s2_fire;
  upsm_pkg::s2_ctl_t             s2_ctl;

  logic                          out_free;
  logic                          out_load;
  logic                          forward_r;
  logic                          too_short_r;
  logic [upsm_pkg::MASK_W-1:0]   match_mask_r;
  logic [upsm_pkg::COUNT_W-1:0]  frame_counter;
  logic [upsm_pkg::COUNT_W-1:0]  frame_counter_next;

  logic [POS_W-1:0]              pos;
  logic [POS_W-1:0]              flen;
  upsm_pkg::hdr_status_t         hdr_status;

  logic [NUM_SIGNATURES-1:0]     lane_ok;
  logic [NUM_SIGNATURES-1:0]     lane_en;
  logic [NUM_SIGNATURES+upsm_pkg::MASK_W-1:0] ok_ext;
  logic [upsm_pkg::MASK_W-1:0]   mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      inspect_port    <= upsm_pkg::PORT_RESET;
      signature_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        upsm_pkg::REG_INSPECT_PORT: inspect_port    <= cfg_data;
        upsm_pkg::REG_SIG_COUNT:    signature_count <= cfg_data[upsm_pkg::SCNT_W-1:0];
      endcase
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s2_emit       = s2_valid && s2_frame && s2_last;
  assign s2_adv        = !s2_emit || out_free;
  assign s2_fire       = s2_valid && s2_adv;
  assign s1_adv        = !s1_valid || s2_adv;
  assign s1_fire       = s1_valid && s1_adv;
  assign s_axis_tready = s1_adv;
  assign out_load      = s2_fire && s2_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s1_adv) begin
      s1_item.cmd        <= upsm_pkg::cmd_t'(s_axis_tuser);
      s1_item.data_byte  <= s_axis_tdata[7:0];
      s1_item.last_byte  <= s_axis_tlast;
      s1_item.sig_index  <= s_axis_tdata[9:8];
      s1_item.sig_offset <= s_axis_tdata[20:10];
      s1_item.sig_length <= s_axis_tdata[25:21];
      s1_item.char_pos   <= s_axis_tdata[30:26];
    end
  end

  upsm_hdr_check #(
    .MAX_FRAME (MAX_FRAME),
    .POS_W     (POS_W)
  ) u_hdr (
    .clk          (clk),
    .rst          (rst),
    .fire         (s1_fire && s1_item.cmd == upsm_pkg::CMD_FRAME_BYTE),
    .data_byte    (s1_item.data_byte),
    .last_byte    (s1_item.last_byte),
    .inspect_port (inspect_port),
    .pos          (pos),
    .flen         (flen),
    .status       (hdr_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
    if (s1_fire) begin
      s2_frame <= (s1_item.cmd == upsm_pkg::CMD_FRAME_BYTE);
      s2_last  <= s1_item.last_byte;
      s2_byte  <= s1_item.data_byte;
      s2_fwd   <= hdr_status.header_good && !hdr_status.short_frame;
      s2_short <= hdr_status.short_frame;
    end
  end

  assign s2_ctl.fire  = s2_fire;
  assign s2_ctl.frame = s2_frame;
  assign s2_ctl.last  = s2_last;
  assign s2_ctl.data  = s2_byte;

  for (genvar g = 0; g < NUM_SIGNATURES; g++) begin : g_lane
    upsm_sig_lane #(
      .LANE     (g),
      .MAX_WORD (MAX_WORD),
      .POS_W    (POS_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .s1_fire (s1_fire),
      .item    (s1_item),
      .pos     (pos),
      .flen    (flen),
      .pos_ok  (hdr_status.pos_ok),
      .s2      (s2_ctl),
      .lane_ok (lane_ok[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_SIGNATURES; i++) begin
      lane_en[i] = (int'(signature_count) > i);
    end
  end

  assign ok_ext             = {{upsm_pkg::MASK_W{1'b0}}, lane_ok & lane_en};
  assign mask               = s2_fwd ? ok_ext[upsm_pkg::MASK_W-1:0] : '0;
  assign frame_counter_next = s2_fwd ? frame_counter + 64'd1 : frame_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      frame_counter <= '0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      frame_counter <= frame_counter_next;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) begin
      forward_r    <= s2_fwd;
      too_short_r  <= s2_short;
      match_mask_r <= mask;
    end
  end

  assign m_axis_tdata = {2'b00, frame_counter, match_mask_r, too_short_r, forward_r};

  `UPSM_ASSERT_IMP(a_short_not_fwd, m_axis_tvalid && too_short_r, !forward_r, "short frame forwarded")
  `UPSM_ASSERT_IMP(a_mask_needs_fwd, m_axis_tvalid && !forward_r, match_mask_r == '0, "mask without forward")
  `UPSM_ASSERT_NXT(a_count_step, out_load && s2_fwd, frame_counter == $past(frame_counter) + 64'd1, "counter step")
  `UPSM_ASSERT_NXT(a_s2_hold, s2_valid && !s2_adv, s2_valid && $stable(s2_byte), "stalled stage lost")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import upsm_pkg::*;

  localparam int SIG_SLOTS = 4;
  localparam int SIG_CHARS = 20;
  localparam int FRAME_CAP = 2048;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int ITEM_TARGET = 560;
  localparam int PHASE_LEN = 80;
  localparam int NUM_PHASES = 7;
  localparam int QUIET_PHASE = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [CPOS_W-1:0] cpos;
  } stim_t;

  localparam int STIM_W = $bits(stim_t);

  typedef struct packed {
    logic               forward;
    logic               runt;
    logic [MASK_W-1:0]  mask;
    logic [COUNT_W-1:0] count;
  } verdict_t;

  typedef enum int {ROW_ITEM, ROW_FRAME, ROW_CFG} row_kind_t;
  typedef enum int {FLT_NONE, FLT_ETYPE_HI, FLT_ETYPE_LO, FLT_VER, FLT_PROTO, FLT_NOISE} flt_t;

  typedef struct {
    row_kind_t   kind;
    stim_t       it;
    logic        reg_idx;
    logic [15:0] reg_val;
    int          flen;
    flt_t        fault;
    int          dport;
    bit          fixed;
    verdict_t    fv;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [PORT_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  udp_port_offset_signature_matcher_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // filter state mirror
  logic [OFF_W-1:0]  sig_off[SIG_SLOTS];
  logic [LEN_W-1:0]  sig_len[SIG_SLOTS];
  logic [BYTE_W-1:0] sig_chr[SIG_SLOTS][SIG_CHARS];
  bit                hit_ok[SIG_SLOTS] = '{default: 1'b1};
  int                fpos = 0;
  bit                hdr_ok = 1'b1;
  logic [BYTE_W-1:0] dport_hi = '0;
  logic [COUNT_W-1:0] fwd_count = '0;
  logic [PORT_W-1:0] cur_port = PORT_RESET;
  logic [SCNT_W-1:0] cur_cnt = '0;

  verdict_t verdict_q[$];
  verdict_t seen_v;
  logic [BYTE_W-1:0] frame_buf[$];
  row_t dir_tab[$];

  int idle_pct = 10;
  int stall_pct = 10;
  int n_err = 0;
  int n_items = 0;
  int n_results = 0;
  int n_fwd = 0;
  int n_runt = 0;
  int n_hits = 0;
  int quiet_cycles = 0;

  function automatic bit predict_verdict(input stim_t it, output verdict_t v);
    int rel;
    int used;
    bit ok;
    v = '0;
    case (it.cmd)
      CMD_SET_SIG: begin
        sig_off[it.idx] = it.off;
        sig_len[it.idx] = (it.len > SIG_CHARS) ? LEN_W'(SIG_CHARS) : it.len;
        return 1'b0;
      end
      CMD_SET_CHAR: begin
        if (it.cpos < SIG_CHARS) sig_chr[it.idx][it.cpos] = it.data;
        return 1'b0;
      end
      CMD_FRAME_BYTE: ;
      default: return 1'b0;
    endcase
    if (fpos < FRAME_CAP) begin
      if (fpos == POS_ETYPE_HI && it.data != ETYPE_HI_VAL) hdr_ok = 1'b0;
      if (fpos == POS_ETYPE_LO && it.data != ETYPE_LO_VAL) hdr_ok = 1'b0;
      if (fpos == POS_VER_IHL && it.data != VER_IHL_VAL) hdr_ok = 1'b0;
      if (fpos == POS_PROTO && it.data != PROTO_UDP) hdr_ok = 1'b0;
      if (fpos == POS_DPORT_HI) dport_hi = it.data;
      if (fpos == POS_DPORT_LO && {dport_hi, it.data} != cur_port) hdr_ok = 1'b0;
      if (fpos >= HDR_BYTES) begin
        rel = fpos - HDR_BYTES;
        for (int s = 0; s < SIG_SLOTS; s++) begin
          if (rel >= int'(sig_off[s]) && rel - int'(sig_off[s]) < int'(sig_len[s]) &&
              sig_chr[s][rel - int'(sig_off[s])] != it.data)
            hit_ok[s] = 1'b0;
        end
      end
      fpos++;
    end
    if (!it.last) return 1'b0;
    v.runt = fpos < HDR_BYTES;
    v.forward = hdr_ok && !v.runt;
    used = (cur_cnt > SIG_SLOTS) ? SIG_SLOTS : int'(cur_cnt);
    if (v.forward) begin
      fwd_count++;
      for (int s = 0; s < used; s++) begin
        ok = (sig_len[s] == 0) ||
             (hit_ok[s] && HDR_BYTES + int'(sig_off[s]) + int'(sig_len[s]) <= fpos);
        if (ok) v.mask[s] = 1'b1;
      end
    end
    v.count = fwd_count;
    fpos = 0;
    hdr_ok = 1'b1;
    dport_hi = '0;
    hit_ok = '{default: 1'b1};
    return 1'b1;
  endfunction

  task automatic send_item(input stim_t it, input bit fixed, input verdict_t fv);
    verdict_t v;
    bit got;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {1'b0, it.cpos, it.len, it.off, it.idx, it.data};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    got = predict_verdict(it, v);
    if (got) begin
      if (fixed) begin
        v.forward = fv.forward;
        v.runt    = fv.runt;
        v.mask    = fv.mask;
      end
      verdict_q.push_back(v);
      n_results++;
      n_fwd += v.forward;
      n_runt += v.runt;
      n_hits += $countones(v.mask);
    end
    if (it.cmd != CMD_SPARE && !(it.cmd == CMD_SET_CHAR && it.cpos >= SIG_CHARS)) n_items++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INSPECT_PORT) cur_port = val;
    else cur_cnt = val[SCNT_W-1:0];
  endtask

  function automatic stim_t rand_table_item();
    stim_t it;
    int r;
    it = stim_t'(STIM_W'({$urandom, $urandom}));
    r = $urandom_range(99);
    it.cmd = (r < 45) ? CMD_SET_SIG : (r < 90) ? CMD_SET_CHAR : CMD_SPARE;
    r = $urandom_range(99);
    if (r < 70) it.off = OFF_W'($urandom_range(0, 40));
    else if (r < 80) it.off = OFF_W'(FRAME_CAP - 1);
    r = $urandom_range(99);
    if (r < 10) it.len = '0;
    else if (r < 20) it.len = LEN_W'($urandom_range(21, 31));
    else if (r < 30) it.len = LEN_W'(SIG_CHARS);
    else it.len = LEN_W'($urandom_range(1, 8));
    it.cpos = ($urandom_range(99) < 85) ? CPOS_W'($urandom_range(0, SIG_CHARS - 1))
                                        : CPOS_W'($urandom_range(SIG_CHARS, 31));
    return it;
  endfunction

  // builds one frame and sends it; mix_pct interleaves random non-frame items (mostly table writes) between bytes
  task automatic run_frame(input int flen, input flt_t fault, input logic [15:0] dport,
                           input int plant_pct, input int mix_pct,
                           input bit fixed, input verdict_t fv);
    logic [BYTE_W-1:0] b;
    stim_t it;
    int p;
    frame_buf.delete();
    for (int i = 0; i < flen; i++) begin
      b = BYTE_W'($urandom);
      if (fault != FLT_NOISE) begin
        case (i)
          POS_ETYPE_HI: b = ETYPE_HI_VAL;
          POS_ETYPE_LO: b = ETYPE_LO_VAL;
          POS_VER_IHL:  b = VER_IHL_VAL;
          POS_PROTO:    b = PROTO_UDP;
          POS_DPORT_HI: b = dport[15:8];
          POS_DPORT_LO: b = dport[7:0];
          default: ;
        endcase
        if ((fault == FLT_ETYPE_HI && i == POS_ETYPE_HI) ||
            (fault == FLT_ETYPE_LO && i == POS_ETYPE_LO) ||
            (fault == FLT_VER && i == POS_VER_IHL) ||
            (fault == FLT_PROTO && i == POS_PROTO))
          b = b ^ (8'h01 << $urandom_range(7));
      end
      frame_buf.push_back(b);
    end
    for (int s = 0; s < SIG_SLOTS; s++) begin
      if ($urandom_range(99) < plant_pct) begin
        for (int k = 0; k < sig_len[s]; k++) begin
          p = HDR_BYTES + sig_off[s] + k;
          if (p < flen) frame_buf[p] = sig_chr[s][k];
        end
        if (sig_len[s] != 0 && $urandom_range(3) == 0) begin
          p = HDR_BYTES + sig_off[s] + $urandom_range(0, sig_len[s] - 1);
          if (p < flen) frame_buf[p] = frame_buf[p] ^ (8'h01 << $urandom_range(7));
        end
      end
    end
    for (int i = 0; i < flen; i++) begin
      it = stim_t'(STIM_W'({$urandom, $urandom}));
      it.cmd  = CMD_FRAME_BYTE;
      it.data = frame_buf[i];
      it.last = (i == flen - 1);
      send_item(it, fixed, fv);
      if (i != flen - 1 && $urandom_range(99) < mix_pct) send_item(rand_table_item(), 1'b0, '0);
    end
  endtask

  function automatic row_t mk_item(input logic [CMD_W-1:0] cmd, input logic [7:0] data,
                                   input logic last, input int idx, input int off,
                                   input int len, input int cpos);
    row_t r;
    r.kind  = ROW_ITEM;
    r.fixed = 1'b0;
    r.it    = {cmd, data, last, IDX_W'(idx), OFF_W'(off), LEN_W'(len), CPOS_W'(cpos)};
    return r;
  endfunction

  function automatic row_t mk_frame(input int flen, input flt_t fault, input int dport,
                                    input bit fixed, input logic fwd, input logic runt,
                                    input logic [MASK_W-1:0] mask);
    row_t r;
    r.kind  = ROW_FRAME;
    r.flen  = flen;
    r.fault = fault;
    r.dport = dport;
    r.fixed = fixed;
    r.fv    = '{forward: fwd, runt: runt, mask: mask, count: '0};
    return r;
  endfunction

  function automatic row_t mk_cfg(input logic idx, input logic [15:0] val);
    row_t r;
    r.kind    = ROW_CFG;
    r.fixed   = 1'b0;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result with none expected: tdata %h", m_axis_tdata);
        n_err++;
      end else begin
        seen_v = verdict_q.pop_front();
        if (m_axis_tdata[0] !== seen_v.forward) begin
          $error("forward: expected %0d, got %0d", seen_v.forward, m_axis_tdata[0]);
          n_err++;
        end
        if (m_axis_tdata[1] !== seen_v.runt) begin
          $error("too_short: expected %0d, got %0d", seen_v.runt, m_axis_tdata[1]);
          n_err++;
        end
        if (m_axis_tdata[5:2] !== seen_v.mask) begin
          $error("match_mask: expected %h, got %h", seen_v.mask, m_axis_tdata[5:2]);
          n_err++;
        end
        if (m_axis_tdata[69:6] !== seen_v.count) begin
          $error("inspected_count: expected %0d, got %0d", seen_v.count, m_axis_tdata[69:6]);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_t it;
    row_t r;
    logic [15:0] ph_port[NUM_PHASES];
    logic [SCNT_W-1:0] ph_cnt[NUM_PHASES];
    int base;
    int phase;
    int pick;
    int flen;
    flt_t fault;
    logic [15:0] dp;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // load the whole signature table so no entry is read unwritten
    for (int s = 0; s < SIG_SLOTS; s++) begin
      it = stim_t'(STIM_W'({$urandom, $urandom}));
      it.cmd = CMD_SET_SIG;
      it.idx = IDX_W'(s);
      it.off = '0;
      it.len = '0;
      send_item(it, 1'b0, '0);
    end
    for (int s = 0; s < SIG_SLOTS; s++) begin
      for (int c = 0; c < SIG_CHARS; c++) begin
        it = stim_t'(STIM_W'({$urandom, $urandom}));
        it.cmd  = CMD_SET_CHAR;
        it.idx  = IDX_W'(s);
        it.cpos = CPOS_W'(c);
        send_item(it, 1'b0, '0);
      end
    end

    dir_tab.push_back(mk_frame(42, FLT_NONE, -1, 1, 1'b1, 1'b0, 4'h0));
    dir_tab.push_back(mk_frame(41, FLT_NONE, -1, 1, 1'b0, 1'b1, 4'h0));
    dir_tab.push_back(mk_frame(1, FLT_NONE, -1, 1, 1'b0, 1'b1, 4'h0));
    dir_tab.push_back(mk_cfg(REG_SIG_COUNT, 16'd4));
    dir_tab.push_back(mk_item(CMD_SET_CHAR, 8'h00, 1'b1, 0, 0, 0, 0));
    dir_tab.push_back(mk_item(CMD_SET_CHAR, 8'hFF, 1'b0, 0, 2047, 31, 1));
    dir_tab.push_back(mk_item(CMD_SET_SIG, 8'h00, 1'b1, 0, 0, 2, 0));
    dir_tab.push_back(mk_item(CMD_SET_SIG, 8'hFF, 1'b0, 1, 2047, 20, 31));
    dir_tab.push_back(mk_item(CMD_SET_SIG, 8'h00, 1'b0, 2, 3, 31, 0));
    dir_tab.push_back(mk_item(CMD_SET_SIG, 8'h00, 1'b0, 3, 0, 0, 0));
    dir_tab.push_back(mk_item(CMD_SET_CHAR, 8'hA5, 1'b1, 3, 0, 0, 20));
    dir_tab.push_back(mk_item(CMD_SET_CHAR, 8'h5A, 1'b0, 3, 0, 0, 31));
    dir_tab.push_back(mk_item(CMD_SPARE, 8'hFF, 1'b1, 3, 2047, 31, 31));
    dir_tab.push_back(mk_frame(64, FLT_NONE, -1, 0, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_frame(80, FLT_ETYPE_HI, -1, 1, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_frame(80, FLT_ETYPE_LO, -1, 1, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_frame(80, FLT_VER, -1, 1, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_frame(80, FLT_PROTO, -1, 1, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_frame(60, FLT_NONE, 5002, 1, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_frame(30, FLT_PROTO, -1, 1, 1'b0, 1'b1, 4'h0));
    dir_tab.push_back(mk_cfg(REG_SIG_COUNT, 16'hFFFF));
    dir_tab.push_back(mk_frame(50, FLT_NONE, -1, 0, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_cfg(REG_INSPECT_PORT, 16'h0000));
    dir_tab.push_back(mk_frame(45, FLT_NONE, -1, 0, 1'b0, 1'b0, 4'h0));
    dir_tab.push_back(mk_cfg(REG_INSPECT_PORT, 16'hFFFF));
    dir_tab.push_back(mk_frame(42, FLT_NONE, -1, 0, 1'b0, 1'b0, 4'h0));

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      case (r.kind)
        ROW_ITEM: send_item(r.it, 1'b0, '0);
        ROW_CFG:  write_reg(r.reg_idx, r.reg_val);
        default: begin
          dp = (r.dport < 0) ? cur_port : 16'(r.dport);
          run_frame(r.flen, r.fault, dp, 100, 0, r.fixed, r.fv);
        end
      endcase
    end

    ph_port = '{16'd5001, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom)};
    ph_cnt  = '{3'd4, 3'd7, 3'd4, 3'd5, 3'd2, 3'd0, 3'd3};
    base = n_items;
    phase = -1;
    while (n_items - base < ITEM_TARGET) begin
      if (phase < NUM_PHASES - 1 && n_items - base >= (phase + 1) * PHASE_LEN) begin
        phase++;
        write_reg(REG_INSPECT_PORT, ph_port[phase]);
        write_reg(REG_SIG_COUNT, {13'($urandom), ph_cnt[phase]});
        idle_pct  = (phase == QUIET_PHASE) ? 0 : 10;
        stall_pct = (phase == QUIET_PHASE) ? 0 : 10;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          flen = $urandom_range(1, HDR_BYTES - 1);
        end else begin
          flen = HDR_BYTES + $urandom_range(0, 60);
        end
        fault = ($urandom_range(99) < 85) ? FLT_NONE : flt_t'($urandom_range(1, 4));
        dp = ($urandom_range(99) < 90) ? cur_port : 16'($urandom);
        run_frame(flen, fault, dp, 75, 3, 1'b0, '0);
      end else if (pick < 82) begin
        run_frame($urandom_range(1, 80), FLT_NOISE, 16'h0, 0, 3, 1'b0, '0);
      end else begin
        send_item(rand_table_item(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d effective transfers across %0d register phases; %0d frame results checked.",
             n_items, phase + 1, n_results);
    $display("Forwarded %0d, too short %0d, signature hits %0d.",
             n_fwd, n_runt, n_hits);
    if (n_err == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
